// ===== hw/rtl/lpse_pkg.sv =====
// Shared types and constants for the LED pixel SPI encoder.
`timescale 1ns / 1ps
`default_nettype none
package lpse_pkg;

  // Line codes for one strip bit
  localparam logic [7:0] CODE_ONE  = 8'hE0;
  localparam logic [7:0] CODE_ZERO = 8'h80;
  localparam logic [7:0] CODE_NONE = 8'h00;

  // Bits per pixel and the index of the final bit
  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam logic [4:0]  LAST_BIT       = 5'd23;

  // Brightness scaling: (c*pct + 50) / 100, division by reciprocal 5243 / 2^19
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [14:0] ROUND_HALF  = 15'd50;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  // Register map, selected by paddr[2]
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_LED_COUNT  = 1'b1;

  localparam logic [6:0]  BRIGHTNESS_RST = 7'd100;
  localparam logic [10:0] LED_COUNT_RST  = 11'd1024;

  // Scaled pixel handed to the serializer
  typedef struct packed {
    logic [23:0] word;       // G,R,B after scaling
    logic [14:0] base;       // pixel_index * 24
    logic        err;        // index rejected
  } pixel_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lpse_pix_if.sv =====
// Valid/ready channel that carries one pixel write.
`timescale 1ns / 1ps
`default_nettype none
interface lpse_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output pixel_index, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input pixel_index, input red, input green, input blue,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lpse_byte_if.sv =====
// Valid/ready channel that carries one line-coded SPI byte.
`timescale 1ns / 1ps
`default_nettype none
interface lpse_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  spi_byte;
  logic [14:0] byte_offset;
  logic        last_byte;
  logic        index_error;

  modport source (output valid, output spi_byte, output byte_offset, output last_byte,
                  output index_error, input ready);
  modport sink (input valid, input spi_byte, input byte_offset, input last_byte,
                input index_error, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lpse_serializer.sv =====
// Serializer: turns one scaled pixel into 24 line-coded bytes (one for a rejected index) behind an output register.
`timescale 1ns / 1ps
`default_nettype none
module lpse_serializer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pix_valid,
  input  wire lpse_pkg::pixel_t pix,
  output logic                 pix_ready,
  lpse_byte_if.source          out_byte
);
  import lpse_pkg::*;

  logic        ser_v_r;
  logic [23:0] word_r;
  logic [14:0] off_r;
  logic [4:0]  cnt_r;
  logic        err_r;

  logic        ov_r;
  logic [7:0]  byte_r;
  logic [14:0] boff_r;
  logic        last_r;
  logic        berr_r;

  logic        emit;
  logic        ser_last;
  logic [7:0]  code_nxt;

  // Emit a byte when one is pending and the output slot is free or draining
  assign emit      = ser_v_r && (!ov_r || out_byte.ready);
  assign ser_last  = err_r || (cnt_r == LAST_BIT);
  assign pix_ready = !ser_v_r || (emit && ser_last);

  always_comb begin
    if (err_r) begin
      code_nxt = CODE_NONE;
    end else if (word_r[23]) begin
      code_nxt = CODE_ONE;
    end else begin
      code_nxt = CODE_ZERO;
    end
  end

  // Control: serializer occupancy and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (pix_ready) begin
        ser_v_r <= pix_valid;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_byte.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Load a new pixel or advance one bit
  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      word_r <= pix.word;
      off_r  <= pix.err ? 15'd0 : pix.base;
      cnt_r  <= 5'd0;
      err_r  <= pix.err;
    end else if (emit) begin
      word_r <= {word_r[22:0], 1'b0};
      off_r  <= off_r + 15'd1;
      cnt_r  <= cnt_r + 5'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= code_nxt;
      boff_r <= off_r;
      last_r <= ser_last;
      berr_r <= err_r;
    end
  end

  assign out_byte.valid       = ov_r;
  assign out_byte.spi_byte    = byte_r;
  assign out_byte.byte_offset = boff_r;
  assign out_byte.last_byte   = last_r;
  assign out_byte.index_error = berr_r;

endmodule
`default_nettype wire

// ===== hw/rtl/led_pixel_spi_encoder_unit.sv =====
// Top level of the LED pixel SPI encoder: config registers, scaling pipeline, serializer.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted pixel write yields 24 result transactions, one SPI byte per strip bit
// (0xE0 for a one, 0x80 for a zero) in G,R,B order, MSB first, the last one marked; an
// index at or above min(led_count, MAX_LEDS) yields a single transaction with
// index_error set. Colors are scaled by the brightness percentage with halves rounded
// up. A pixel passes three register stages (range check, multiply by brightness,
// reciprocal divide by 100) and then the serializer, so the first byte appears on
// out_byte after the serializer's pixel and output registers. The serializer sends one
// byte per cycle while out_byte is ready, so a pixel holds it for 24 bytes (a rejected
// index for one); pixels may be taken every cycle until the stages fill. Registers sit at
// byte address 0 (brightness, dropped if pwdata[6:0] > 100) and 4 (led_count).
module led_pixel_spi_encoder_unit #(
  parameter int unsigned MAX_LEDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lpse_pix_if.sink         in_pix,
  lpse_byte_if.source      out_byte,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import lpse_pkg::*;

  localparam logic [16:0] MAX_LEDS_W = 17'(MAX_LEDS);

  logic [6:0]  bright_r;
  logic [10:0] led_count_r;
  logic        cfg_wr;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r    <= BRIGHTNESS_RST;
      led_count_r <= LED_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_BRIGHTNESS: begin
          if (cfg_pwdata[6:0] <= PCT_FULL) begin
            bright_r <= cfg_pwdata[6:0];
          end
        end
        REG_LED_COUNT: led_count_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_BRIGHTNESS: cfg_prdata = {25'd0, bright_r};
      REG_LED_COUNT:  cfg_prdata = {21'd0, led_count_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // Stage enables: a stage loads when empty or when its contents move on
  logic ser_ready;
  logic en1, en2, en3;
  logic s1_v_r, s2_v_r, s3_v_r;

  assign en3          = !s3_v_r || ser_ready;
  assign en2          = !s2_v_r || en3;
  assign en1          = !s1_v_r || en2;
  assign in_pix.ready = en1;

  // Stage 1: capture pixel and check index against clamped LED count
  logic [16:0] limit;
  logic        idx_err;
  logic [9:0]  s1_idx_r;
  logic [7:0]  s1_r_r, s1_g_r, s1_b_r;
  logic        s1_err_r;

  always_comb begin
    if ({6'd0, led_count_r} > MAX_LEDS_W) begin
      limit = MAX_LEDS_W;
    end else begin
      limit = {6'd0, led_count_r};
    end
    idx_err = {7'd0, in_pix.pixel_index} >= limit;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_idx_r <= in_pix.pixel_index;
      s1_r_r   <= in_pix.red;
      s1_g_r   <= in_pix.green;
      s1_b_r   <= in_pix.blue;
      s1_err_r <= idx_err;
    end
  end

  // Stage 2: multiply by brightness and add the rounding half; form frame offset
  logic [14:0] s2_pr_r, s2_pg_r, s2_pb_r;
  logic [14:0] s2_base_r;
  logic        s2_err_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_pr_r   <= 15'(s1_r_r * bright_r) + ROUND_HALF;
      s2_pg_r   <= 15'(s1_g_r * bright_r) + ROUND_HALF;
      s2_pb_r   <= 15'(s1_b_r * bright_r) + ROUND_HALF;
      s2_base_r <= {1'b0, s1_idx_r, 4'd0} + {2'd0, s1_idx_r, 3'd0};
      s2_err_r  <= s1_err_r;
    end
  end

  // Stage 3: divide by 100 through the reciprocal and pack G,R,B
  logic [27:0] qr, qg, qb;
  pixel_t      s3_pix_r;

  assign qr = s2_pr_r * RECIP_100;
  assign qg = s2_pg_r * RECIP_100;
  assign qb = s2_pb_r * RECIP_100;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pix_r.word <= {qg[RECIP_SHIFT +: 8], qr[RECIP_SHIFT +: 8], qb[RECIP_SHIFT +: 8]};
      s3_pix_r.base <= s2_base_r;
      s3_pix_r.err  <= s2_err_r;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_r <= in_pix.valid;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  lpse_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (s3_v_r),
    .pix       (s3_pix_r),
    .pix_ready (ser_ready),
    .out_byte  (out_byte)
  );

endmodule
`default_nettype wire

// ===== sim/led_pixel_spi_encoder_unit_tb.sv =====
// Self-checking testbench for the LED pixel SPI encoder: directed and random pixel writes.
`timescale 1ns / 1ps
module led_pixel_spi_encoder_unit_tb;
  import lpse_pkg::*;

  // One line-coded byte as seen on the result channel
  typedef struct packed {
    logic [7:0]  spi_byte;
    logic [14:0] byte_offset;
    logic        last_byte;
    logic        index_error;
  } spi_byte_t;

  localparam logic [2:0] ADDR_BRIGHTNESS = {REG_BRIGHTNESS, 2'b00};
  localparam logic [2:0] ADDR_LED_COUNT  = {REG_LED_COUNT, 2'b00};
  localparam int unsigned STRIP_MAX      = 1024;
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lpse_pix_if  pix_if ();
  lpse_byte_if byte_if ();

  // Shadow of the register file and the bytes still to come
  logic [6:0]  shadow_brightness;
  logic [10:0] shadow_led_count;
  spi_byte_t   pending_bytes[$];

  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  led_pixel_spi_encoder_unit #(.MAX_LEDS(STRIP_MAX)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (pix_if),
    .out_byte    (byte_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Hold every input at a known value from time zero
  initial begin
    rst_n          = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_index = '0;
    pix_if.red         = '0;
    pix_if.green       = '0;
    pix_if.blue        = '0;
    byte_if.ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
  end

  // Stall the result channel at the configured rate
  always @(posedge clk) begin
    byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Brightness scaling with halves rounded up
  function automatic logic [7:0] scale_color(input logic [7:0] c, input logic [6:0] pct);
    int unsigned v;
    v = (int'(c) * int'(pct) + 50) / 100;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Queue the bytes that one accepted pixel write produces
  task automatic predict_pixel_bytes(input logic [9:0] idx, input logic [7:0] r,
                                     input logic [7:0] g, input logic [7:0] b);
    int unsigned limit;
    logic [23:0] grb;
    spi_byte_t   item;
    limit = (shadow_led_count > STRIP_MAX) ? STRIP_MAX : shadow_led_count;
    if (idx >= limit) begin
      item = '{spi_byte: CODE_NONE, byte_offset: '0, last_byte: 1'b1, index_error: 1'b1};
      pending_bytes.push_back(item);
    end else begin
      grb = {scale_color(g, shadow_brightness), scale_color(r, shadow_brightness),
             scale_color(b, shadow_brightness)};
      for (int i = 0; i < BITS_PER_PIXEL; i++) begin
        item.spi_byte    = grb[BITS_PER_PIXEL - 1 - i] ? CODE_ONE : CODE_ZERO;
        item.byte_offset = 15'(int'(idx) * BITS_PER_PIXEL + i);
        item.last_byte   = (i == BITS_PER_PIXEL - 1);
        item.index_error = 1'b0;
        pending_bytes.push_back(item);
      end
    end
  endtask

  // Compare each result transaction with the oldest pending byte
  always @(posedge clk) begin
    spi_byte_t want;
    if (rst_n && byte_if.valid && byte_if.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("byte with nothing pending, offset", byte_if.byte_offset, 0);
      end else begin
        want = pending_bytes.pop_front();
        if (byte_if.spi_byte !== want.spi_byte)
          report_mismatch("spi_byte", byte_if.spi_byte, want.spi_byte);
        if (byte_if.byte_offset !== want.byte_offset)
          report_mismatch("byte_offset", byte_if.byte_offset, want.byte_offset);
        if (byte_if.last_byte !== want.last_byte)
          report_mismatch("last_byte", byte_if.last_byte, want.last_byte);
        if (byte_if.index_error !== want.index_error)
          report_mismatch("index_error", byte_if.index_error, want.index_error);
      end
    end
  end

  // Send one pixel write, idling first at the configured rate
  task automatic send_pixel(input logic [9:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid       <= 1'b0;
      pix_if.pixel_index <= 10'($urandom);
      pix_if.red         <= 8'($urandom);
      @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_index <= idx;
    pix_if.red         <= r;
    pix_if.green       <= g;
    pix_if.blue        <= b;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    predict_pixel_bytes(idx, r, g, b);
  endtask

  // Drop valid and wait until every pending byte has arrived
  task automatic drain_bytes();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    // Mirror the register update
    if (addr == ADDR_BRIGHTNESS) begin
      if (data[6:0] <= PCT_FULL) shadow_brightness = data[6:0];
    end else if (addr == ADDR_LED_COUNT) begin
      shadow_led_count = data[10:0];
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [2:0] addr);
    logic [31:0] want;
    want = (addr == ADDR_BRIGHTNESS) ? 32'(shadow_brightness) : 32'(shadow_led_count);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= 32'($urandom);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) report_mismatch("register read", cfg_prdata, want);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reset values, then write and read back both registers
  task automatic test_register_access();
    cfg_read_check(ADDR_BRIGHTNESS);
    cfg_read_check(ADDR_LED_COUNT);
    cfg_write(ADDR_BRIGHTNESS, 32'd77);
    cfg_read_check(ADDR_BRIGHTNESS);
    cfg_write(ADDR_LED_COUNT, 32'd300);
    cfg_read_check(ADDR_LED_COUNT);
    cfg_write(ADDR_BRIGHTNESS, 32'(BRIGHTNESS_RST));
    cfg_write(ADDR_LED_COUNT, 32'(LED_COUNT_RST));
  endtask

  // Field extremes at full brightness
  task automatic test_pixel_extremes();
    send_pixel(10'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(10'd1023, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(10'd682, 8'hAA, 8'h55, 8'hFF);
    send_pixel(10'd341, 8'h55, 8'hAA, 8'h00);
    drain_bytes();
  endtask

  // Rounding, zero brightness and ignored writes above full scale
  task automatic test_brightness_scaling();
    cfg_write(ADDR_BRIGHTNESS, 32'd0);
    send_pixel(10'd5, 8'hFF, 8'hFF, 8'hFF);
    drain_bytes();
    cfg_write(ADDR_BRIGHTNESS, 32'd1);
    send_pixel(10'd6, 8'hFF, 8'd49, 8'd50);
    drain_bytes();
    cfg_write(ADDR_BRIGHTNESS, 32'd50);
    send_pixel(10'd7, 8'd1, 8'd3, 8'd255);
    send_pixel(10'd8, 8'd5, 8'd2, 8'd127);
    drain_bytes();
    // Out-of-range writes leave the previous value in place
    cfg_write(ADDR_BRIGHTNESS, 32'd101);
    cfg_read_check(ADDR_BRIGHTNESS);
    send_pixel(10'd9, 8'd201, 8'd99, 8'd1);
    drain_bytes();
    cfg_write(ADDR_BRIGHTNESS, 32'd127);
    // Bits above the field are dropped
    cfg_write(ADDR_BRIGHTNESS, 32'hFFFF_FF80 | 32'd37);
    cfg_read_check(ADDR_BRIGHTNESS);
    send_pixel(10'd10, 8'd200, 8'd100, 8'd33);
    drain_bytes();
    cfg_write(ADDR_BRIGHTNESS, 32'(BRIGHTNESS_RST));
  endtask

  // Index bounds: single LED, zero count, clamped count, mid-range edge
  task automatic test_index_bounds();
    cfg_write(ADDR_LED_COUNT, 32'd1);
    send_pixel(10'd0, 8'd12, 8'd34, 8'd56);
    send_pixel(10'd1, 8'd12, 8'd34, 8'd56);
    drain_bytes();
    cfg_write(ADDR_LED_COUNT, 32'd0);
    send_pixel(10'd0, 8'hFF, 8'd0, 8'hFF);
    drain_bytes();
    cfg_write(ADDR_LED_COUNT, 32'd2047);
    send_pixel(10'd1023, 8'd1, 8'd2, 8'd3);
    drain_bytes();
    cfg_write(ADDR_LED_COUNT, 32'hFFFF_F800 | 32'd513);
    cfg_read_check(ADDR_LED_COUNT);
    send_pixel(10'd512, 8'd9, 8'd8, 8'd7);
    send_pixel(10'd513, 8'd9, 8'd8, 8'd7);
    drain_bytes();
    cfg_write(ADDR_LED_COUNT, 32'd1024);
    send_pixel(10'd1023, 8'd128, 8'd64, 8'd32);
    drain_bytes();
  endtask

  function automatic logic [7:0] pick_color();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly in-range indexes, some boundary and out-of-range ones
  function automatic logic [9:0] pick_index();
    int unsigned limit;
    int unsigned roll;
    limit = (shadow_led_count > STRIP_MAX) ? STRIP_MAX : shadow_led_count;
    roll  = $urandom_range(99);
    if (limit == 0 || roll < 8) return 10'($urandom_range(1023));
    if (roll < 12) return (limit < STRIP_MAX) ? 10'(limit) : 10'(limit - 1);
    return 10'($urandom_range(limit - 1));
  endfunction

  // Random traffic under one idling mix, with a new register setting per segment
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [31:0] bright_word;
    logic [31:0] count_word;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 4; seg++) begin
      drain_bytes();
      case ($urandom_range(3))
        0: bright_word = 32'd0;
        1: bright_word = 32'd100;
        default: bright_word = {25'($urandom), 7'($urandom_range(127))};
      endcase
      case ($urandom_range(4))
        0: count_word = 32'd1;
        1: count_word = 32'd1024;
        2: count_word = {21'($urandom), 11'($urandom_range(2047, 1))};
        default: count_word = 32'($urandom_range(1024, 1));
      endcase
      cfg_write(ADDR_BRIGHTNESS, bright_word);
      cfg_write(ADDR_LED_COUNT, count_word);
      for (int n = 0; n < 24; n++) begin
        send_pixel(pick_index(), pick_color(), pick_color(), pick_color());
      end
    end
    drain_bytes();
  endtask

  // Run limit
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    shadow_brightness = BRIGHTNESS_RST;
    shadow_led_count  = LED_COUNT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_pixel_extremes();
    test_brightness_scaling();
    test_index_bounds();
    test_random_traffic(0, 0);
    test_random_traffic(68, 0);
    test_random_traffic(0, 68);
    test_random_traffic(34, 34);

    // Let the pipeline settle so stray bytes are caught
    drain_bytes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0)
      report_mismatch("bytes never delivered", pending_bytes.size(), 0);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
